>>> sv/crc16fp_pkg.sv
`timescale 1ns / 1ps

package crc16fp_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_GOOD   = 2'd1,
    ST_BADCRC = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_MAX_FRAME_LEN = 2'd2
  } reg_idx_e;

  localparam logic [8:0] MinFrame  = 9'd9;
  localparam logic [8:0] Overhead  = 9'd9;
  localparam logic [7:0] DataStart = 8'd5;
  localparam logic [7:0] LenPosLast = 8'd4;

  localparam logic [15:0] CrcTable [256] = '{
    16'h2ae2, 16'hf965, 16'ha429, 16'h1b33, 16'hd0ce, 16'hd13a, 16'h69c2, 16'he829,
    16'ha785, 16'hbec6, 16'he141, 16'h3093, 16'hb528, 16'h94d3, 16'hdfb9, 16'h5c62,
    16'h98c2, 16'h6fad, 16'h234b, 16'h8f03, 16'hba66, 16'h1ebb, 16'h2060, 16'hb68e,
    16'h68c9, 16'ha3b5, 16'hbceb, 16'h17dc, 16'h7b28, 16'h63ba, 16'h91aa, 16'ha60b,
    16'h5d20, 16'h35d4, 16'hc13e, 16'h2def, 16'h870e, 16'h2b01, 16'h9618, 16'hae94,
    16'h69c7, 16'h775a, 16'hdf27, 16'h1ef1, 16'h0c2e, 16'h3ee1, 16'hfb52, 16'h24f0,
    16'hae8e, 16'h1e9e, 16'h33f3, 16'he8f4, 16'hbd58, 16'hd452, 16'h1f83, 16'h2622,
    16'h7808, 16'h5c6f, 16'h3dfe, 16'h7331, 16'hc029, 16'h4fa8, 16'h193d, 16'h1d4a,
    16'h057d, 16'hda7b, 16'hcb38, 16'h8c8b, 16'h857d, 16'h6151, 16'h3b20, 16'h6f44,
    16'h58ab, 16'h9a47, 16'h8e35, 16'he4d9, 16'h5928, 16'h0988, 16'h09ca, 16'h87b6,
    16'ha825, 16'hbdbd, 16'h70ab, 16'h657e, 16'h9210, 16'h102f, 16'h0ba1, 16'h8a19,
    16'h6c9e, 16'hc99e, 16'hfd4a, 16'h2cc8, 16'h1948, 16'h9687, 16'hca11, 16'h1ec5,
    16'hf102, 16'h954a, 16'h2b50, 16'h7680, 16'h769b, 16'he670, 16'he5c5, 16'hcf46,
    16'h00b8, 16'hf3fa, 16'h3420, 16'h59e1, 16'h7d83, 16'hbdea, 16'he197, 16'h25a9,
    16'h7ba8, 16'hd243, 16'h8b28, 16'h8db8, 16'he272, 16'h96c9, 16'h17d2, 16'h4f11,
    16'he067, 16'h951c, 16'h7bd9, 16'hf9af, 16'h2ba4, 16'h45eb, 16'h9874, 16'h9ca7,
    16'h5b35, 16'hc3c5, 16'h9327, 16'h51d0, 16'h2a36, 16'h78ed, 16'h2117, 16'h2aee,
    16'hece8, 16'hd537, 16'h84cf, 16'hea6b, 16'h9322, 16'he667, 16'h1015, 16'h0ecb,
    16'hb8ab, 16'h9b3d, 16'h9c83, 16'h9b1e, 16'hb206, 16'h3456, 16'hea2f, 16'h126f,
    16'h4972, 16'he608, 16'h0c1f, 16'hf516, 16'habf3, 16'h2494, 16'h91be, 16'h0729,
    16'h6859, 16'h24e6, 16'hd8f8, 16'h928f, 16'h1dd4, 16'h7a0f, 16'hbd7d, 16'h8abc,
    16'h4f47, 16'hc24d, 16'h7528, 16'he269, 16'h28b5, 16'h853d, 16'hf134, 16'he160,
    16'ha07b, 16'h0db9, 16'h7c7f, 16'hd281, 16'hc20e, 16'he6ae, 16'he4f0, 16'h0b81,
    16'hccb7, 16'h7110, 16'h0098, 16'hf8aa, 16'h95a4, 16'h1256, 16'h7fd3, 16'hfdfd,
    16'h373d, 16'h58cc, 16'h908d, 16'hd510, 16'hd2db, 16'hce0a, 16'h5fcd, 16'h2224,
    16'h1058, 16'hd4f5, 16'h048e, 16'h390d, 16'hda32, 16'h75c3, 16'h9a6d, 16'hfaad,
    16'h837c, 16'h16ed, 16'hcd30, 16'hc58a, 16'h7d9b, 16'h3221, 16'hd10b, 16'hca52,
    16'ha331, 16'h51a4, 16'hc2fd, 16'h38d6, 16'he3f9, 16'h42d1, 16'hb6d3, 16'h1b37,
    16'h9b9d, 16'hc760, 16'h7047, 16'h6e7a, 16'h956c, 16'hd014, 16'h109e, 16'h25c4,
    16'h250a, 16'h952b, 16'hded1, 16'h7f3d, 16'h0aef, 16'h793f, 16'h79eb, 16'h0e6b,
    16'h902d, 16'hc71b, 16'hd3f5, 16'h8dc8, 16'hf93d, 16'h2502, 16'h581c, 16'h9c6f,
    16'hf6a5, 16'h1b1a, 16'h5546, 16'hda9f, 16'h5dec, 16'h8c19, 16'h75d7, 16'h7989
  };

endpackage

>>> sv/crc16_frame_parser_top.sv
`timescale 1ns / 1ps
// An accepted byte's result is registered and valid on the master side next cycle.
// Throughput: one byte per cycle; one CRC table lookup and the parse update per byte.
// Input is taken whenever the result register is empty or drained in the same cycle.
// Reset (rst_ni low, asynchronous) returns to header hunt with cleared state and
// registers header_first 0, header_second 0, max_frame_length 255.

module crc16_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // byte_out, payload_index, frame_kind, data_length
  output logic        m_axis_tlast_o,   // frame_end
  output logic [2:0]  m_axis_tuser_o    // is_payload, frame_status[1:0]
);

  logic [7:0] hdr_first_q, hdr_second_q, max_len_q;

  crc16fp_pkg::phase_e phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  first_q, first_d;
  logic [15:0] first_crc_q, first_crc_d;
  logic [7:0]  len_total_q, len_total_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rx_crc_q, rx_crc_d;

  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_pidx_q, out_kind_q, out_dlen_q;
  logic        out_payload_q, out_end_q;
  crc16fp_pkg::status_e out_status_q;

  logic        payload;
  logic [7:0]  pidx, kind_out, dlen_out;
  logic        fend;
  crc16fp_pkg::status_e status;

  logic        in_fire;
  logic [7:0]  rx_byte;
  logic [15:0] crc_base, crc_step;
  logic [7:0]  first_lut_idx;
  logic [8:0]  want_len, crc_hi, pos_ext;

  assign rx_byte         = s_axis_tdata_i;
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= 8'd0;
      hdr_second_q <= 8'd0;
      max_len_q    <= 8'hff;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crc16fp_pkg::REG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i;
        crc16fp_pkg::REG_HEADER_SECOND: hdr_second_q <= cfg_data_i;
        crc16fp_pkg::REG_MAX_FRAME_LEN: max_len_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // crc_base is the running CRC the current byte folds into
  assign crc_base = (phase_q == crc16fp_pkg::PH_HUNT) ? first_crc_q : crc_q;
  assign crc_step = crc16fp_pkg::CrcTable[crc_base[15:8] ^ rx_byte] ^ {crc_base[7:0], 8'h00};
  assign first_lut_idx = (pos_q == 8'd0) ? rx_byte : hdr_first_q;
  assign want_len = {1'b0, rx_byte} + crc16fp_pkg::Overhead;
  assign crc_hi   = {1'b0, dlen_q} + {1'b0, crc16fp_pkg::DataStart};
  assign pos_ext  = {1'b0, pos_q};

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    first_d     = first_q;
    first_crc_d = first_crc_q;
    len_total_d = len_total_q;
    kind_d      = kind_q;
    dlen_d      = dlen_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    unique case (phase_q)
      crc16fp_pkg::PH_HUNT: begin
        if (pos_q == 8'd0) begin
          first_d     = rx_byte;
          first_crc_d = crc16fp_pkg::CrcTable[first_lut_idx];
          pos_d       = 8'd1;
        end else if (first_q == hdr_first_q && rx_byte == hdr_second_q) begin
          crc_d       = crc_step;
          kind_d      = 8'd0;
          dlen_d      = 8'd0;
          len_total_d = 8'd0;
          rx_crc_d    = 16'd0;
          phase_d     = crc16fp_pkg::PH_LEN;
          pos_d       = 8'd2;
        end else if (rx_byte == hdr_first_q) begin
          first_d     = hdr_first_q;
          first_crc_d = crc16fp_pkg::CrcTable[first_lut_idx];
          pos_d       = 8'd1;
        end else begin
          pos_d = 8'd0;
        end
      end
      crc16fp_pkg::PH_LEN: begin
        crc_d = crc_step;
        if (pos_q == 8'd2) begin
          len_total_d = rx_byte;
        end else if (pos_q == 8'd3) begin
          kind_d = rx_byte;
        end else begin
          dlen_d = rx_byte;
        end
        if (pos_q >= crc16fp_pkg::LenPosLast) begin
          if (len_total_q > max_len_q || {1'b0, len_total_q} < crc16fp_pkg::MinFrame ||
              {1'b0, len_total_q} != want_len) begin
            phase_d = crc16fp_pkg::PH_HUNT;
            pos_d   = 8'd0;
          end else begin
            phase_d = crc16fp_pkg::PH_BODY;
            pos_d   = crc16fp_pkg::DataStart;
          end
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      crc16fp_pkg::PH_BODY: begin
        if (pos_ext < crc_hi) begin
          crc_d = crc_step;
        end else if (pos_ext == crc_hi) begin
          rx_crc_d = {rx_byte, 8'h00};
        end else if (pos_ext == crc_hi + 9'd1) begin
          rx_crc_d = {rx_crc_q[15:8], rx_byte};
        end
        if (pos_ext + 9'd1 >= {1'b0, len_total_q}) begin
          phase_d = crc16fp_pkg::PH_HUNT;
          pos_d   = 8'd0;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      default: begin
        phase_d = crc16fp_pkg::PH_HUNT;
        pos_d   = 8'd0;
      end
    endcase
  end

  always_comb begin
    payload  = 1'b0;
    pidx     = 8'd0;
    fend     = 1'b0;
    status   = crc16fp_pkg::ST_BUSY;
    kind_out = 8'd0;
    dlen_out = 8'd0;
    unique case (phase_q)
      crc16fp_pkg::PH_LEN: begin
        kind_out = kind_d;
        dlen_out = dlen_d;
        if (pos_q >= crc16fp_pkg::LenPosLast && phase_d == crc16fp_pkg::PH_HUNT) begin
          fend   = 1'b1;
          status = crc16fp_pkg::ST_BADLEN;
        end
      end
      crc16fp_pkg::PH_BODY: begin
        kind_out = kind_q;
        dlen_out = dlen_q;
        if (pos_ext < crc_hi) begin
          payload = 1'b1;
          pidx    = pos_q - crc16fp_pkg::DataStart;
        end
        if (phase_d == crc16fp_pkg::PH_HUNT) begin
          fend   = 1'b1;
          status = (crc_d == rx_crc_d) ? crc16fp_pkg::ST_GOOD : crc16fp_pkg::ST_BADCRC;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= crc16fp_pkg::PH_HUNT;
      pos_q       <= 8'd0;
      first_q     <= 8'd0;
      first_crc_q <= crc16fp_pkg::CrcTable[0];
      len_total_q <= 8'd0;
      kind_q      <= 8'd0;
      dlen_q      <= 8'd0;
      crc_q       <= 16'd0;
      rx_crc_q    <= 16'd0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      first_crc_q <= first_crc_d;
      len_total_q <= len_total_d;
      kind_q      <= kind_d;
      dlen_q      <= dlen_d;
      crc_q       <= crc_d;
      rx_crc_q    <= rx_crc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q    <= rx_byte;
      out_pidx_q    <= pidx;
      out_kind_q    <= kind_out;
      out_dlen_q    <= dlen_out;
      out_payload_q <= payload;
      out_end_q     <= fend;
      out_status_q  <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_dlen_q, out_kind_q, out_pidx_q, out_byte_q};
  assign m_axis_tlast_o  = out_end_q;
  assign m_axis_tuser_o  = {out_status_q, out_payload_q};

  a_last_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_status_q != crc16fp_pkg::ST_BUSY)
    else $error("frame end without final status");

  a_busy_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_end_q |-> out_status_q == crc16fp_pkg::ST_BUSY)
    else $error("final status on a mid-frame byte");

  a_payload_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_payload_q |-> !out_end_q)
    else $error("payload byte marked as frame end");

  a_body_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == crc16fp_pkg::PH_BODY |-> pos_q >= crc16fp_pkg::DataStart)
    else $error("body phase before data start");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted byte produced no result");

endmodule

>>> tb/crc16_frame_parser_top_test.sv
`timescale 1ns / 1ps

module crc16_frame_parser_top_test;

  localparam int unsigned CycleLimit = 400000;

  typedef enum int unsigned {
    FR_GOOD,
    FR_BAD_CRC,
    FR_LEN_OFF,
    FR_LEN_SHORT,
    FR_CUT
  } frame_fault_e;

  typedef struct packed {
    logic [7:0]           byte_out;
    logic                 is_payload;
    logic [7:0]           payload_index;
    logic                 frame_end;
    crc16fp_pkg::status_e frame_status;
    logic [7:0]           frame_kind;
    logic [7:0]           data_length;
  } parse_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = crc16fp_pkg::REG_HEADER_FIRST;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [2:0]  m_axis_tuser_o;

  crc16_frame_parser_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // parser shadow state and register copies
  logic [7:0]          hdr_first_cfg = 8'h00;
  logic [7:0]          hdr_second_cfg = 8'h00;
  logic [7:0]          max_len_cfg = 8'hff;
  crc16fp_pkg::phase_e parse_ph = crc16fp_pkg::PH_HUNT;
  logic [7:0]          parse_pos = 8'h00;
  logic [7:0]          first_seen = 8'h00;
  logic [7:0]          len_total = 8'h00;
  logic [7:0]          kind_seen = 8'h00;
  logic [7:0]          dlen_seen = 8'h00;
  logic [15:0]         crc_run = 16'h0000;
  logic [15:0]         crc_rx = 16'h0000;

  logic [7:0]  rx_pending_q[$];
  parse_out_t  predicted_parse_q[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    return crc16fp_pkg::CrcTable[crc[15:8] ^ b] ^ {crc[7:0], 8'h00};
  endfunction

  function automatic parse_out_t parse_byte(logic [7:0] b);
    parse_out_t r;
    logic [8:0] crc_hi;
    r = '0;
    r.byte_out = b;
    r.frame_status = crc16fp_pkg::ST_BUSY;
    case (parse_ph)
      crc16fp_pkg::PH_HUNT: begin
        if (parse_pos == 8'd0) begin
          first_seen = b;
          parse_pos = 8'd1;
        end else if (first_seen == hdr_first_cfg && b == hdr_second_cfg) begin
          crc_run = crc_step(crc_step(16'h0000, first_seen), b);
          kind_seen = 8'h00;
          dlen_seen = 8'h00;
          len_total = 8'h00;
          crc_rx = 16'h0000;
          parse_ph = crc16fp_pkg::PH_LEN;
          parse_pos = 8'd2;
        end else if (b == hdr_first_cfg) begin
          first_seen = hdr_first_cfg;
          parse_pos = 8'd1;
        end else begin
          parse_pos = 8'd0;
        end
      end
      crc16fp_pkg::PH_LEN: begin
        crc_run = crc_step(crc_run, b);
        if (parse_pos == 8'd2) len_total = b;
        else if (parse_pos == 8'd3) kind_seen = b;
        else dlen_seen = b;
        r.frame_kind = kind_seen;
        r.data_length = dlen_seen;
        if (parse_pos >= crc16fp_pkg::LenPosLast) begin
          if (len_total > max_len_cfg || {1'b0, len_total} < crc16fp_pkg::MinFrame ||
              {1'b0, len_total} != {1'b0, dlen_seen} + crc16fp_pkg::Overhead) begin
            r.frame_end = 1'b1;
            r.frame_status = crc16fp_pkg::ST_BADLEN;
            parse_ph = crc16fp_pkg::PH_HUNT;
            parse_pos = 8'd0;
          end else begin
            parse_ph = crc16fp_pkg::PH_BODY;
            parse_pos = crc16fp_pkg::DataStart;
          end
        end else begin
          parse_pos = parse_pos + 8'd1;
        end
      end
      default: begin
        crc_hi = {1'b0, crc16fp_pkg::DataStart} + {1'b0, dlen_seen};
        r.frame_kind = kind_seen;
        r.data_length = dlen_seen;
        if ({1'b0, parse_pos} < crc_hi) begin
          r.is_payload = 1'b1;
          r.payload_index = parse_pos - crc16fp_pkg::DataStart;
          crc_run = crc_step(crc_run, b);
        end else if ({1'b0, parse_pos} == crc_hi) begin
          crc_rx = {b, 8'h00};
        end else if ({1'b0, parse_pos} == crc_hi + 9'd1) begin
          crc_rx[7:0] = b;
        end
        if ({1'b0, parse_pos} + 9'd1 >= {1'b0, len_total}) begin
          r.frame_end = 1'b1;
          r.frame_status = (crc_run == crc_rx) ? crc16fp_pkg::ST_GOOD :
                                                 crc16fp_pkg::ST_BADCRC;
          parse_ph = crc16fp_pkg::PH_HUNT;
          parse_pos = 8'd0;
        end else begin
          parse_pos = parse_pos + 8'd1;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted_parse_q.push_back(parse_byte(s_axis_tdata_i));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (rx_pending_q.size() != 0) begin
          s_axis_tdata_i <= rx_pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    parse_out_t exp_r;
    logic rdy;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (predicted_parse_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata %h", m_axis_tdata_o);
          mismatches++;
        end else begin
          exp_r = predicted_parse_q.pop_front();
          if (m_axis_tdata_o[7:0] != exp_r.byte_out) begin
            $error("byte_out: expected %h, actual %h", exp_r.byte_out, m_axis_tdata_o[7:0]);
            mismatches++;
          end
          if (m_axis_tuser_o[0] != exp_r.is_payload) begin
            $error("is_payload: expected %0d, actual %0d", exp_r.is_payload,
                   m_axis_tuser_o[0]);
            mismatches++;
          end
          if (m_axis_tdata_o[15:8] != exp_r.payload_index) begin
            $error("payload_index: expected %0d, actual %0d", exp_r.payload_index,
                   m_axis_tdata_o[15:8]);
            mismatches++;
          end
          if (m_axis_tlast_o != exp_r.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", exp_r.frame_end, m_axis_tlast_o);
            mismatches++;
          end
          if (m_axis_tuser_o[2:1] != exp_r.frame_status) begin
            $error("frame_status: expected %0d, actual %0d", exp_r.frame_status,
                   m_axis_tuser_o[2:1]);
            mismatches++;
          end
          if (m_axis_tdata_o[23:16] != exp_r.frame_kind) begin
            $error("frame_kind: expected %h, actual %h", exp_r.frame_kind,
                   m_axis_tdata_o[23:16]);
            mismatches++;
          end
          if (m_axis_tdata_o[31:24] != exp_r.data_length) begin
            $error("data_length: expected %0d, actual %0d", exp_r.data_length,
                   m_axis_tdata_o[31:24]);
            mismatches++;
          end
        end
      end
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = (stall_tick % 3 == 0);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      m_axis_tready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(crc16fp_pkg::reg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      crc16fp_pkg::REG_HEADER_FIRST:  hdr_first_cfg = val;
      crc16fp_pkg::REG_HEADER_SECOND: hdr_second_cfg = val;
      default:                        max_len_cfg = val;
    endcase
  endtask

  task automatic set_config(logic [7:0] first_v, logic [7:0] second_v, logic [7:0] max_v);
    write_reg(crc16fp_pkg::REG_HEADER_FIRST, first_v);
    write_reg(crc16fp_pkg::REG_HEADER_SECOND, second_v);
    write_reg(crc16fp_pkg::REG_MAX_FRAME_LEN, max_v);
    @(negedge clk_i);
  endtask

  // hold the sender until every queued byte has been parsed and checked
  task automatic wait_idle();
    while (rx_pending_q.size() != 0 || s_axis_tvalid_i || predicted_parse_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_frame(int unsigned dlen, frame_fault_e fault);
    logic [7:0]  fr[$];
    logic [7:0]  total;
    logic [15:0] crc;
    int unsigned keep;
    total = 8'(dlen + 9);
    if (fault == FR_LEN_OFF) total = 8'(dlen + 9 + $urandom_range(1, 20));
    if (fault == FR_LEN_SHORT) total = 8'($urandom_range(0, 8));
    fr.push_back(hdr_first_cfg);
    fr.push_back(hdr_second_cfg);
    fr.push_back(total);
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(8'(dlen));
    repeat (dlen) fr.push_back(8'($urandom_range(0, 255)));
    crc = 16'h0000;
    foreach (fr[i]) crc = crc_step(crc, fr[i]);
    if (fault == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    fr.push_back(crc[15:8]);
    fr.push_back(crc[7:0]);
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(8'($urandom_range(0, 255)));
    keep = fr.size();
    if (fault == FR_LEN_OFF || fault == FR_LEN_SHORT) keep = 5 + $urandom_range(0, 3);
    if (fault == FR_CUT) keep = $urandom_range(2, fr.size() - 2);
    for (int unsigned i = 0; i < keep; i++) rx_pending_q.push_back(fr[i]);
  endtask

  task automatic queue_random(int unsigned n_bytes, int unsigned dmax);
    int unsigned goal;
    int unsigned pick;
    int unsigned dlen;
    goal = rx_pending_q.size() + n_bytes;
    while (rx_pending_q.size() < goal) begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 3) == 0) rx_pending_q.push_back(hdr_first_cfg);
        else rx_pending_q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0) dlen = $urandom_range(0, dmax);
      else dlen = $urandom_range(0, (dmax < 12) ? dmax : 12);
      pick = $urandom_range(0, 99);
      if (pick < 65) queue_frame(dlen, FR_GOOD);
      else if (pick < 80) queue_frame(dlen, FR_BAD_CRC);
      else if (pick < 87) queue_frame(dlen, FR_LEN_OFF);
      else if (pick < 92) queue_frame(dlen, FR_LEN_SHORT);
      else queue_frame(dlen, FR_CUT);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    queue_frame(0, FR_GOOD);
    rx_pending_q.push_back(8'hff);
    rx_pending_q.push_back(8'h00);
    wait_idle();

    set_config(8'haa, 8'h55, 8'hff);
    rx_pending_q.push_back(8'haa);
    queue_frame(0, FR_GOOD);
    queue_frame(0, FR_BAD_CRC);
    queue_frame(1, FR_LEN_SHORT);
    queue_frame(2, FR_LEN_OFF);
    queue_random(30, 40);
    queue_frame(246, FR_GOOD);
    wait_idle();

    set_config(8'hff, 8'h00, 8'd9);
    queue_random(25, 3);
    wait_idle();

    set_config(8'h00, 8'hff, 8'd8);
    queue_random(15, 3);
    wait_idle();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd16);
    queue_frame(10, FR_GOOD);
    queue_random(40, 12);
    wait_idle();

    if (mismatches == 0 && predicted_parse_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
